FILE: rtl/core/h2r_pkg.sv
`timescale 1ns / 1ps
// h2r_pkg: shared constants and types for the hsv to rgb converter
// no dependencies; imported by hsv_to_rgb_converter, h2r_cmax_div and hsv_to_rgb_checker

package h2r_pkg;

    // whole-degree part of the hue field
    localparam int HUE_INT_BITS   = 9;

    // one sector is 60 degrees, split as an odd factor and a power of two
    localparam int DEG_PER_SECTOR = 60;
    localparam int SECTOR_ODD     = 15;
    localparam int SECTOR_POW2    = 2;

    // a full-width hue field reaches up to sector 8
    localparam int SECTOR_LAST    = 8;
    localparam int SECTOR_BITS    = 4;

    typedef logic [SECTOR_BITS-1:0] sector_t;

    localparam sector_t SEC_RED_YELLOW   = 4'd0;
    localparam sector_t SEC_YELLOW_GREEN = 4'd1;
    localparam sector_t SEC_GREEN_CYAN   = 4'd2;
    localparam sector_t SEC_CYAN_BLUE    = 4'd3;
    localparam sector_t SEC_BLUE_MAGENTA = 4'd4;
    localparam sector_t SEC_MAGENTA_RED  = 4'd5;

    // load enables for the two register stages of a divider
    typedef struct packed {
        logic load_a;
        logic load_b;
    } div_ctl_t;

endpackage

FILE: rtl/core/h2r_cmax_div.sv
`timescale 1ns / 1ps
// h2r_cmax_div: two-stage rounded division by (2^COLOR_BITS - 1) << SHIFT
// uses h2r_pkg for the stage load control struct

module h2r_cmax_div #(
    parameter int COLOR_BITS = 8,
    parameter int SHIFT      = 0,
    parameter int NUM_BITS   = 16
) (
    input  logic                    clk,
    input  h2r_pkg::div_ctl_t       ctl,
    input  logic [NUM_BITS-1:0]     num,
    output logic [COLOR_BITS-1:0]   quot
);

    localparam int XW = 2 * COLOR_BITS;
    localparam int SW = SHIFT + XW + 1;
    localparam logic [SW-1:0] BIAS =
        SW'((((64'd1 << COLOR_BITS) - 64'd1) << SHIFT) >> 1);
    localparam logic [XW:0] CMAX = (XW+1)'((64'd1 << COLOR_BITS) - 64'd1);

    logic [SW-1:0]          biased;
    logic [XW-1:0]          x_next;
    logic [XW-1:0]          x_reg;
    logic [XW-1:0]          xb_reg;
    logic [XW:0]            est_sum;
    logic [COLOR_BITS:0]    est_next;
    logic [COLOR_BITS:0]    est_reg;
    logic [XW:0]            est_prod;
    logic [XW:0]            resid;
    logic [COLOR_BITS:0]    quot_full;

    // rounding bias, then drop the power-of-two part of the divisor
    assign biased = SW'(num) + BIAS;
    assign x_next = biased[SHIFT +: XW];

    // x / (2^n - 1) estimate, never high and at most one low
    assign est_sum  = {1'b0, x_reg} + (XW+1)'(x_reg >> COLOR_BITS);
    assign est_next = est_sum[XW -: (COLOR_BITS + 1)];

    always_ff @(posedge clk)
    begin
        if (ctl.load_a)
        begin
            x_reg <= x_next;
        end
        if (ctl.load_b)
        begin
            est_reg <= est_next;
            xb_reg  <= x_reg;
        end
    end

    // remainder check and single correction step
    assign est_prod  = ((XW+1)'(est_reg) << COLOR_BITS) - (XW+1)'(est_reg);
    assign resid     = {1'b0, xb_reg} - est_prod;
    assign quot_full = (resid >= CMAX) ? est_reg + 1'b1 : est_reg;
    assign quot      = quot_full[COLOR_BITS-1:0];

endmodule

FILE: rtl/core/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
// hsv_to_rgb_converter: eight-stage pipelined hsv to rgb pixel conversion
// throughput: one item per cycle while the output is not stalled, set by the eight-stage register pipeline
// stalls hold items in place; empty stages keep accepting while the output waits
// reset clears only the stage valid bits; no state survives between items
// depends on h2r_pkg and h2r_cmax_div

module hsv_to_rgb_converter #(
    parameter int  COLOR_BITS    = 8,
    parameter int  HUE_FRAC_BITS = 6,
    localparam int HUE_BITS      = h2r_pkg::HUE_INT_BITS + HUE_FRAC_BITS,
    localparam int IN_BITS       = ((HUE_BITS + 2 * COLOR_BITS + 7) / 8) * 8,
    localparam int OUT_BITS      = ((3 * COLOR_BITS + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // hue, saturation, brightness from bit 0 up
    input  logic [IN_BITS-1:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // red, green, blue from bit 0 up
    output logic [OUT_BITS-1:0] m_axis_tdata
);

    import h2r_pkg::*;

    localparam int CB          = COLOR_BITS;
    localparam int STAGES      = 8;
    localparam int ODD_BITS    = $clog2(SECTOR_ODD + 1);
    localparam int YW          = CB + ODD_BITS;
    localparam int SECTOR_SIZE = DEG_PER_SECTOR << HUE_FRAC_BITS;
    localparam logic [CB:0] RECIP = (CB+1)'((64'd1 << YW) / SECTOR_ODD);
    localparam logic [CB:0] FSCALE = (CB+1)'(64'd1 << CB);
    localparam logic [2*CB-1:0] DBIG = (2*CB)'(((64'd1 << CB) - 64'd1) << CB);

    logic [HUE_BITS-1:0]    hue_in;
    logic [CB-1:0]          sat_in;
    logic [CB-1:0]          val_in;

    logic [STAGES-1:0]      adv;
    logic [STAGES-1:0]      vld_next;
    logic [STAGES-1:0]      vld_reg;

    sector_t                sector_reg [STAGES-1];
    logic [CB-1:0]          val_reg    [STAGES-1];
    logic [CB-1:0]          sat_reg    [3];

    sector_t                sector_next;
    logic [HUE_BITS-1:0]    base;
    logic [HUE_BITS-1:0]    rem;
    logic [HUE_BITS+CB-1:0] rem_wide;
    logic [YW-1:0]          y_next;
    logic [YW-1:0]          s1_y_reg;

    logic [YW+CB:0]         y_prod;
    logic [CB-1:0]          fest_next;
    logic [CB-1:0]          s2_fest_reg;
    logic [YW-1:0]          s2_y_reg;

    logic [YW-1:0]          f15;
    logic [YW-1:0]          f_rem;
    logic [CB-1:0]          f_next;
    logic [2*CB-1:0]        np_next;
    logic [CB-1:0]          s3_f_reg;
    logic [2*CB-1:0]        s3_np_reg;

    logic [CB:0]            fc;
    logic [2*CB:0]          sg_full;
    logic [2*CB-1:0]        sf_next;
    logic [2*CB-1:0]        s4_sf_reg;
    logic [2*CB-1:0]        s4_sg_reg;
    logic [2*CB-1:0]        s4_np_reg;

    logic [3*CB-1:0]        nq_next;
    logic [3*CB-1:0]        nt_next;
    logic [3*CB-1:0]        s5_nq_reg;
    logic [3*CB-1:0]        s5_nt_reg;
    logic [2*CB-1:0]        s5_np_reg;

    div_ctl_t               div_ctl;
    logic [CB-1:0]          p_div;
    logic [CB-1:0]          q_div;
    logic [CB-1:0]          t_div;

    logic [CB-1:0]          red_next;
    logic [CB-1:0]          green_next;
    logic [CB-1:0]          blue_next;
    logic [CB-1:0]          red_reg;
    logic [CB-1:0]          green_reg;
    logic [CB-1:0]          blue_reg;

    assign hue_in = s_axis_tdata[HUE_BITS-1:0];
    assign sat_in = s_axis_tdata[HUE_BITS +: CB];
    assign val_in = s_axis_tdata[HUE_BITS + CB +: CB];

    // stall control: a stage moves when it is empty or its successor moves
    always_comb
    begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        vld_next[0] = adv[0] ? s_axis_tvalid : vld_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: sector and hue position scaled down by the power-of-two factor
    always_comb
    begin
        sector_next = SEC_RED_YELLOW;
        base        = '0;
        for (int k = 1; k <= SECTOR_LAST; k++)
        begin
            if (hue_in >= HUE_BITS'(k * SECTOR_SIZE))
            begin
                sector_next = sector_t'(k);
                base        = HUE_BITS'(k * SECTOR_SIZE);
            end
        end
    end

    assign rem      = hue_in - base;
    assign rem_wide = (HUE_BITS+CB)'(rem) << CB;
    assign y_next   = rem_wide[HUE_FRAC_BITS + SECTOR_POW2 +: YW];

    // stage 2: reciprocal estimate of y / 15
    assign y_prod    = (YW+CB+1)'(s1_y_reg) * (YW+CB+1)'(RECIP);
    assign fest_next = y_prod[YW +: CB];

    // stage 3: correct f, form v * (cmax - s)
    assign f15     = YW'(s2_fest_reg) * YW'(SECTOR_ODD);
    assign f_rem   = s2_y_reg - f15;
    assign f_next  = (f_rem >= YW'(SECTOR_ODD)) ? s2_fest_reg + 1'b1 : s2_fest_reg;
    assign np_next = (2*CB)'(val_reg[1]) * {{CB{1'b0}}, ~sat_reg[1]};

    // stage 4: s * f and s * (1 - f)
    assign fc      = FSCALE - {1'b0, s3_f_reg};
    assign sf_next = (2*CB)'(sat_reg[2]) * (2*CB)'(s3_f_reg);
    assign sg_full = (2*CB+1)'(sat_reg[2]) * (2*CB+1)'(fc);

    // stage 5: numerators of q and t
    assign nq_next = (3*CB)'(val_reg[3]) * (3*CB)'(DBIG - s4_sf_reg);
    assign nt_next = (3*CB)'(val_reg[3]) * (3*CB)'(DBIG - s4_sg_reg);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            sector_reg[0] <= sector_next;
            val_reg[0]    <= val_in;
            sat_reg[0]    <= sat_in;
            s1_y_reg      <= y_next;
        end
        if (adv[1])
        begin
            s2_fest_reg <= fest_next;
            s2_y_reg    <= s1_y_reg;
            sat_reg[1]  <= sat_reg[0];
        end
        if (adv[2])
        begin
            s3_f_reg   <= f_next;
            s3_np_reg  <= np_next;
            sat_reg[2] <= sat_reg[1];
        end
        if (adv[3])
        begin
            s4_sf_reg <= sf_next;
            s4_sg_reg <= sg_full[2*CB-1:0];
            s4_np_reg <= s3_np_reg;
        end
        if (adv[4])
        begin
            s5_nq_reg <= nq_next;
            s5_nt_reg <= nt_next;
            s5_np_reg <= s4_np_reg;
        end
        for (int k = 1; k < STAGES - 1; k++)
        begin
            if (adv[k])
            begin
                sector_reg[k] <= sector_reg[k-1];
                val_reg[k]    <= val_reg[k-1];
            end
        end
        if (adv[STAGES-1])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    // stages 6 and 7: rounded constant divisions
    assign div_ctl.load_a = adv[5];
    assign div_ctl.load_b = adv[6];

    h2r_cmax_div #(
        .COLOR_BITS (CB),
        .SHIFT      (0),
        .NUM_BITS   (2 * CB)
    ) u_div_p (
        .clk  (clk),
        .ctl  (div_ctl),
        .num  (s5_np_reg),
        .quot (p_div)
    );

    h2r_cmax_div #(
        .COLOR_BITS (CB),
        .SHIFT      (CB),
        .NUM_BITS   (3 * CB)
    ) u_div_q (
        .clk  (clk),
        .ctl  (div_ctl),
        .num  (s5_nq_reg),
        .quot (q_div)
    );

    h2r_cmax_div #(
        .COLOR_BITS (CB),
        .SHIFT      (CB),
        .NUM_BITS   (3 * CB)
    ) u_div_t (
        .clk  (clk),
        .ctl  (div_ctl),
        .num  (s5_nt_reg),
        .quot (t_div)
    );

    // stage 8: sector select; zero saturation already gives p = q = t = v
    always_comb
    begin
        case (sector_reg[STAGES-2])
            SEC_RED_YELLOW:
            begin
                red_next   = val_reg[STAGES-2];
                green_next = t_div;
                blue_next  = p_div;
            end
            SEC_YELLOW_GREEN:
            begin
                red_next   = q_div;
                green_next = val_reg[STAGES-2];
                blue_next  = p_div;
            end
            SEC_GREEN_CYAN:
            begin
                red_next   = p_div;
                green_next = val_reg[STAGES-2];
                blue_next  = t_div;
            end
            SEC_CYAN_BLUE:
            begin
                red_next   = p_div;
                green_next = q_div;
                blue_next  = val_reg[STAGES-2];
            end
            SEC_BLUE_MAGENTA:
            begin
                red_next   = t_div;
                green_next = p_div;
                blue_next  = val_reg[STAGES-2];
            end
            default:
            begin
                red_next   = val_reg[STAGES-2];
                green_next = p_div;
                blue_next  = q_div;
            end
        endcase
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = vld_reg[STAGES-1];
    assign m_axis_tdata  = OUT_BITS'({blue_reg, green_reg, red_reg});

    a_ready_with_room: assert property (
        @(posedge clk) disable iff (!rst_n)
        (vld_reg != '1) |-> s_axis_tready
    ) else $error("input stalled while a pipeline stage is empty");

    a_item_count: assert property (
        @(posedge clk) disable iff (!rst_n)
        $past(rst_n) |->
            ($countones(vld_reg) == $past($countones(vld_reg))
                + int'($past(s_axis_tvalid && s_axis_tready))
                - int'($past(m_axis_tvalid && m_axis_tready)))
    ) else $error("pipeline occupancy does not match accepted and delivered items");

    a_channel_order: assert property (
        @(posedge clk) disable iff (!rst_n)
        vld_reg[STAGES-2] |->
            (p_div <= q_div && p_div <= t_div
                && q_div <= val_reg[STAGES-2] && t_div <= val_reg[STAGES-2])
    ) else $error("divider results out of order p <= q, t <= v");

endmodule

FILE: tb/hsv_to_rgb_checker.sv
`timescale 1ns / 1ps
// hsv_to_rgb_checker: watches both stream ports of the converter, predicts each pixel
// and compares the returned rgb item field by field; depends on h2r_pkg

module hsv_to_rgb_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // hue, saturation, brightness from bit 0 up
    input  logic [31:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // red, green, blue from bit 0 up
    input  logic [23:0] m_axis_tdata,
    output int          mismatches,
    output int          pending,
    output int          checked
);

    import h2r_pkg::*;

    localparam longint unsigned HUE_PER_SECTOR = longint'(DEG_PER_SECTOR) << 6;
    localparam longint unsigned FRAC_STEPS     = 256;
    localparam longint unsigned CMAX           = 255;
    localparam longint unsigned DSCALE         = CMAX * FRAC_STEPS;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    rgb_t expected_rgb[$];

    function automatic rgb_t hsv_pixel_to_rgb(logic [14:0] hue, logic [7:0] sat,
                                              logic [7:0] val);
        longint unsigned h;
        longint unsigned s;
        longint unsigned v;
        longint unsigned remainder;
        longint unsigned frac;
        longint unsigned p;
        longint unsigned q;
        longint unsigned t;
        sector_t         sec;
        rgb_t            rgb;
        h = 64'(hue);
        s = 64'(sat);
        v = 64'(val);
        if (s == 0)
        begin
            rgb.red   = val;
            rgb.green = val;
            rgb.blue  = val;
            return rgb;
        end
        sec       = sector_t'(h / HUE_PER_SECTOR);
        remainder = h % HUE_PER_SECTOR;
        frac      = (remainder * FRAC_STEPS) / HUE_PER_SECTOR;
        // constant divisions rounded to nearest, ties up
        p = (v * (CMAX - s) + CMAX / 2) / CMAX;
        q = (v * (DSCALE - s * frac) + DSCALE / 2) / DSCALE;
        t = (v * (DSCALE - s * (FRAC_STEPS - frac)) + DSCALE / 2) / DSCALE;
        case (sec)
            SEC_RED_YELLOW:   rgb = {p[7:0], t[7:0], val};
            SEC_YELLOW_GREEN: rgb = {p[7:0], val, q[7:0]};
            SEC_GREEN_CYAN:   rgb = {t[7:0], val, p[7:0]};
            SEC_CYAN_BLUE:    rgb = {val, q[7:0], p[7:0]};
            SEC_BLUE_MAGENTA: rgb = {val, p[7:0], t[7:0]};
            default:          rgb = {q[7:0], p[7:0], val};
        endcase
        return rgb;
    endfunction

    always @(posedge clk)
    begin
        rgb_t want;
        rgb_t got;
        if (!rst_n)
        begin
            mismatches = 0;
            pending    = 0;
            checked    = 0;
        end
        else
        begin
            // retire the output item before queuing the input one
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_rgb.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected item r=%0d g=%0d b=%0d",
                                 $realtime, got.red, got.green, got.blue);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_rgb.pop_front();
                    checked = checked + 1;
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue)
                    begin
                        if (mismatches < 10)
                            $display("%0t: rgb expected %0d %0d %0d, got %0d %0d %0d",
                                     $realtime, want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_rgb.push_back(hsv_pixel_to_rgb(s_axis_tdata[14:0],
                                                        s_axis_tdata[22:15],
                                                        s_axis_tdata[30:23]));
            pending = expected_rgb.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: clock, reset and randomly paced pixel stimulus for hsv_to_rgb_converter
// depends on hsv_to_rgb_converter and hsv_to_rgb_checker, and through them on h2r_pkg

module tb_top;

    localparam int HUE_PER_SECTOR = 3840;
    localparam int HUE_TOP        = 23039;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // hue, saturation, brightness from bit 0 up
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // red, green, blue from bit 0 up
    logic [23:0] m_axis_tdata;

    int mismatches;
    int pending;
    int checked;
    int pixels_sent;
    int grey_sent;
    int edge_sent;

    hsv_to_rgb_converter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    hsv_to_rgb_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .pending       (pending),
        .checked       (checked)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // mostly short gaps, some none, a few long
    function automatic int idle_cycles();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic send_pixel(input logic [14:0] hue, input logic [7:0] sat,
                              input logic [7:0] val);
        int gap;
        gap = idle_cycles();
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, val, sat, hue};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pixels_sent = pixels_sent + 1;
        if (sat == 0)
            grey_sent = grey_sent + 1;
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] pick_level();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return 8'd0;
        else if (pick < 20)
            return 8'd255;
        else if (pick < 25)
            return 8'd1;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int run;
            int gap;
            run = $urandom_range(1, 30);
            gap = idle_cycles();
            repeat (run)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            repeat (gap)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("hsv_to_rgb_converter: mismatch");
        $finish;
    end

    initial
    begin
        logic [14:0] hue;
        int          pick;
        int          sec;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        pixels_sent   = 0;
        grey_sent     = 0;
        edge_sent     = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // sector edges, field extremes, grey and first fraction step
        send_pixel(15'd0,     8'd255, 8'd255);
        send_pixel(15'd23039, 8'd255, 8'd255);
        send_pixel(15'd3839,  8'd255, 8'd255);
        send_pixel(15'd3840,  8'd255, 8'd255);
        send_pixel(15'd7679,  8'd255, 8'd255);
        send_pixel(15'd7680,  8'd255, 8'd128);
        send_pixel(15'd11520, 8'd255, 8'd255);
        send_pixel(15'd15359, 8'd200, 8'd255);
        send_pixel(15'd15360, 8'd255, 8'd255);
        send_pixel(15'd19199, 8'd255, 8'd255);
        send_pixel(15'd19200, 8'd255, 8'd255);
        send_pixel(15'd1920,  8'd0,   8'd200);
        send_pixel(15'd12000, 8'd0,   8'd0);
        send_pixel(15'd0,     8'd0,   8'd255);
        send_pixel(15'd23039, 8'd1,   8'd1);
        send_pixel(15'd5000,  8'd255, 8'd0);
        send_pixel(15'd9000,  8'd1,   8'd255);
        send_pixel(15'd16383, 8'd128, 8'd128);
        send_pixel(15'd16384, 8'd170, 8'd85);
        send_pixel(15'd21000, 8'd85,  8'd170);
        send_pixel(15'd14,    8'd255, 8'd255);
        send_pixel(15'd15,    8'd255, 8'd255);
        drain_pipeline();

        for (int n = 0; n < 1100; n++)
        begin
            pick = $urandom_range(0, 99);
            sec  = $urandom_range(0, 5);
            if (pick < 75)
            begin
                hue = 15'($urandom_range(0, HUE_TOP));
            end
            else if (pick < 88)
            begin
                hue = 15'(sec * HUE_PER_SECTOR + $urandom_range(0, 15));
                edge_sent = edge_sent + 1;
            end
            else
            begin
                hue = 15'(sec * HUE_PER_SECTOR + HUE_PER_SECTOR - 1 - $urandom_range(0, 15));
                edge_sent = edge_sent + 1;
            end
            send_pixel(hue, pick_level(), pick_level());
            if (n == 400 || n == 800)
                drain_pipeline();
        end

        drain_pipeline();
        repeat (30) @(negedge clk);

        $display("%0d pixels sent over all six hue sectors (%0d grey, %0d near sector edges)",
                 pixels_sent, grey_sent, edge_sent);
        $display("%0d rgb items compared, %0d wrong", checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("hsv_to_rgb_converter: match");
        else
            $display("hsv_to_rgb_converter: mismatch");
        $finish;
    end

endmodule
